// ===== design/pfs_pkg.sv =====
package pfs_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int MAX_EMIT   = 16;
    localparam int MAX_SCAN   = (NUM_SLOTS < MAX_EMIT) ? NUM_SLOTS : MAX_EMIT;
    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int ID_W       = 29;
    localparam int LEN_W      = 4;
    localparam int DATA_W     = 64;
    localparam int PERIOD_W   = 16;
    localparam int TIME_W     = 64;
    localparam int CYCLE_W    = 26;
    localparam int US_PER_MS  = 1000;
    localparam int MAX_LEN    = 8;

    localparam int S_FIELDS_W = SLOT_W + ID_W + LEN_W + DATA_W + PERIOD_W + TIME_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = SLOT_W + ID_W + LEN_W + DATA_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MSG_COUNT = 1'd1;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        logic [DATA_W-1:0]   data;
        logic [PERIOD_W-1:0] period;
    } frame_t;

    typedef struct packed {
        logic             frame_we;
        logic [IDX_W-1:0] frame_waddr;
        logic             time_we;
        logic [IDX_W-1:0] time_waddr;
        logic [IDX_W-1:0] raddr;
    } tbl_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
    } alu_op_t;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              borrow;
    } alu_res_t;

endpackage

// ===== design/pfs_table.sv =====
module pfs_table (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pfs_pkg::tbl_req_t        req,
    input  pfs_pkg::frame_t          wr_frame,
    input  logic [pfs_pkg::TIME_W-1:0] wr_time,
    output pfs_pkg::frame_t          rd_frame,
    output logic [pfs_pkg::TIME_W-1:0] rd_time
);

    pfs_pkg::frame_t                frame_mem [pfs_pkg::NUM_SLOTS];
    logic [pfs_pkg::TIME_W-1:0]     time_mem  [pfs_pkg::NUM_SLOTS];
    logic [pfs_pkg::NUM_SLOTS-1:0]  time_valid_reg;

    // Last-sent times read as zero until a slot's time has been written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_valid_reg <= '0;
        end else if (req.time_we) begin
            time_valid_reg[req.time_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.frame_we) begin
            frame_mem[req.frame_waddr] <= wr_frame;
        end
        if (req.time_we) begin
            time_mem[req.time_waddr] <= wr_time;
        end
        rd_frame <= frame_mem[req.raddr];
        rd_time  <= time_valid_reg[req.raddr] ? time_mem[req.raddr] : '0;
    end

endmodule

// ===== design/pfs_alu.sv =====
module pfs_alu (
    input  pfs_pkg::alu_op_t  op,
    output pfs_pkg::alu_res_t res
);

    logic [pfs_pkg::TIME_W:0]   full;
    logic [pfs_pkg::TIME_W-1:0] b_eff;

    // Subtraction is a plus the complement of b plus one; a clear carry means a borrow.
    always_comb begin
        b_eff      = op.sub ? ~op.b : op.b;
        full       = {1'b0, op.a} + {1'b0, b_eff} + {{pfs_pkg::TIME_W{1'b0}}, op.sub};
        res.sum    = full[pfs_pkg::TIME_W-1:0];
        res.borrow = op.sub & ~full[pfs_pkg::TIME_W];
    end

endmodule

// ===== design/periodic_frame_scheduler.sv =====
// Periodic frame scheduler. A write request stores one slot and leaves s_tready high. A restart
// request sweeps the last-sent time of every slot, one slot per cycle, and s_tready stays low
// until the sweep ends. An enabled tick request walks the slots in use with one shared 64-bit
// add/subtract unit: a slot that is not due goes through table read, elapsed time, compare and
// step; a due slot also through catch-up check, time update and frame hand-off; a flush step
// ends the walk, and m_tready can hold the frame hand-off and the flush back. Frames leave in
// slot order; m_tlast marks the last frame of a tick, so one frame is held back until the next
// due slot or the end of the walk is known.
module periodic_frame_scheduler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: slot, frame_id, frame_length, frame_data, period_ms, now_us, zero pad
    input  logic [pfs_pkg::S_TDATA_W-1:0]       s_tdata,
    // s_tuser: func
    input  logic [pfs_pkg::FUNC_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0: out_slot, out_id, out_length, out_data, zero pad
    output logic [pfs_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [pfs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int OFS_ID     = pfs_pkg::SLOT_W;
    localparam int OFS_LEN    = OFS_ID + pfs_pkg::ID_W;
    localparam int OFS_DATA   = OFS_LEN + pfs_pkg::LEN_W;
    localparam int OFS_PERIOD = OFS_DATA + pfs_pkg::DATA_W;
    localparam int OFS_NOW    = OFS_PERIOD + pfs_pkg::PERIOD_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SWEEP = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_ELAP  = 4'd3;
    localparam logic [3:0] ST_CMP   = 4'd4;
    localparam logic [3:0] ST_JUMP  = 4'd5;
    localparam logic [3:0] ST_ADV   = 4'd6;
    localparam logic [3:0] ST_EMIT  = 4'd7;
    localparam logic [3:0] ST_NEXT  = 4'd8;
    localparam logic [3:0] ST_FLUSH = 4'd9;

    function automatic logic [pfs_pkg::DATA_W-1:0] payload_mask(
        input logic [pfs_pkg::LEN_W-1:0] len
    );
        logic [pfs_pkg::DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < pfs_pkg::MAX_LEN; b++) begin
            if (pfs_pkg::LEN_W'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    logic [3:0]                      state_reg, state_next;
    logic [pfs_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [pfs_pkg::CNT_W-1:0]       limit_reg, limit_next;
    logic [pfs_pkg::TIME_W-1:0]      now_reg, now_next;
    logic                            enable_reg;
    logic [pfs_pkg::CFG_DATA_W-1:0]  msg_count_reg;
    logic [pfs_pkg::CYCLE_W-1:0]     cycle_reg, cycle_next;
    logic [pfs_pkg::TIME_W-1:0]      elap_reg, elap_next;
    logic [pfs_pkg::TIME_W-1:0]      e2_reg, e2_next;
    logic                            jump_reg, jump_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [pfs_pkg::M_TDATA_W-1:0]   pend_reg, pend_next;
    logic                            m_valid_reg, m_valid_next;
    logic [pfs_pkg::M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic                            m_last_reg, m_last_next;

    pfs_pkg::tbl_req_t               tbl_req;
    pfs_pkg::frame_t                 wr_frame;
    logic [pfs_pkg::TIME_W-1:0]      wr_time;
    pfs_pkg::frame_t                 rd_frame;
    logic [pfs_pkg::TIME_W-1:0]      rd_time;
    pfs_pkg::alu_op_t                alu_op;
    pfs_pkg::alu_res_t               alu_res;

    logic                            accept;
    logic [pfs_pkg::SLOT_W-1:0]      in_slot;
    logic [pfs_pkg::LEN_W-1:0]       in_len;
    logic [pfs_pkg::CNT_W-1:0]       limit_calc;
    logic [pfs_pkg::TIME_W-1:0]      cycle_ext;
    logic [pfs_pkg::M_TDATA_W-1:0]   new_frame;
    logic                            out_free;

    pfs_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (tbl_req),
        .wr_frame (wr_frame),
        .wr_time  (wr_time),
        .rd_frame (rd_frame),
        .rd_time  (rd_time)
    );

    pfs_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_slot  = s_tdata[OFS_ID-1:0];
    assign in_len   = s_tdata[OFS_DATA-1:OFS_LEN];
    assign out_free = !m_valid_reg || m_tready;
    assign cycle_ext = pfs_pkg::TIME_W'(cycle_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign new_frame = pfs_pkg::M_TDATA_W'({rd_frame.data & payload_mask(rd_frame.len),
                                            rd_frame.len, rd_frame.id,
                                            pfs_pkg::SLOT_W'(idx_reg[pfs_pkg::IDX_W-1:0])});

    always_comb begin
        if (32'(msg_count_reg) > pfs_pkg::MAX_SCAN) begin
            limit_calc = pfs_pkg::CNT_W'(pfs_pkg::MAX_SCAN);
        end else begin
            limit_calc = pfs_pkg::CNT_W'(msg_count_reg);
        end
    end

    always_comb begin
        wr_frame.id     = s_tdata[OFS_LEN-1:OFS_ID];
        wr_frame.len    = (in_len > pfs_pkg::LEN_W'(pfs_pkg::MAX_LEN))
                          ? pfs_pkg::LEN_W'(pfs_pkg::MAX_LEN) : in_len;
        wr_frame.data   = s_tdata[OFS_PERIOD-1:OFS_DATA];
        wr_frame.period = s_tdata[OFS_NOW-1:OFS_PERIOD];
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        limit_next      = limit_reg;
        now_next        = now_reg;
        cycle_next      = cycle_reg;
        elap_next       = elap_reg;
        e2_next         = e2_reg;
        jump_next       = jump_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        tbl_req.frame_we    = 1'b0;
        tbl_req.frame_waddr = pfs_pkg::IDX_W'(in_slot);
        tbl_req.time_we     = 1'b0;
        tbl_req.time_waddr  = idx_reg[pfs_pkg::IDX_W-1:0];
        tbl_req.raddr       = idx_reg[pfs_pkg::IDX_W-1:0];
        wr_time             = now_reg;

        alu_op.a   = '0;
        alu_op.b   = '0;
        alu_op.sub = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    now_next = s_tdata[OFS_NOW +: pfs_pkg::TIME_W];
                    idx_next = '0;
                    priority if (s_tuser == pfs_pkg::FUNC_WRITE) begin
                        tbl_req.frame_we = (32'(in_slot) < pfs_pkg::NUM_SLOTS);
                    end else if (s_tuser == pfs_pkg::FUNC_RESTART) begin
                        state_next = ST_SWEEP;
                    end else if (s_tuser == pfs_pkg::FUNC_TICK && enable_reg
                                 && limit_calc != '0) begin
                        limit_next = limit_calc;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP: begin
                tbl_req.time_we = 1'b1;
                if (idx_reg == pfs_pkg::CNT_W'(pfs_pkg::NUM_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = pfs_pkg::CNT_W'(idx_reg + 1'b1);
                end
            end
            ST_READ: begin
                state_next = ST_ELAP;
            end
            ST_ELAP: begin
                alu_op.a   = now_reg;
                alu_op.b   = rd_time;
                alu_op.sub = 1'b1;
                elap_next  = alu_res.sum;
                cycle_next = pfs_pkg::CYCLE_W'(rd_frame.period)
                           * pfs_pkg::CYCLE_W'(pfs_pkg::US_PER_MS);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // The excess over one period; no borrow with a nonzero period means the slot is due.
                alu_op.a   = elap_reg;
                alu_op.b   = cycle_ext;
                alu_op.sub = 1'b1;
                e2_next    = alu_res.sum;
                if (cycle_reg != '0 && !alu_res.borrow) begin
                    state_next = ST_JUMP;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_JUMP: begin
                // Still more than one period behind after advancing: catch up to now.
                alu_op.a   = cycle_ext;
                alu_op.b   = e2_reg;
                alu_op.sub = 1'b1;
                jump_next  = alu_res.borrow;
                state_next = ST_ADV;
            end
            ST_ADV: begin
                alu_op.a        = rd_time;
                alu_op.b        = cycle_ext;
                tbl_req.time_we = 1'b1;
                wr_time         = jump_reg ? now_reg : alu_res.sum;
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                if (!pend_valid_reg) begin
                    pend_valid_next = 1'b1;
                    pend_next       = new_frame;
                    state_next      = ST_NEXT;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    m_last_next  = 1'b0;
                    pend_next    = new_frame;
                    state_next   = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (pfs_pkg::CNT_W'(idx_reg + 1'b1) == limit_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next   = pfs_pkg::CNT_W'(idx_reg + 1'b1);
                    state_next = ST_READ;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = pend_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            limit_reg      <= '0;
            enable_reg     <= 1'b0;
            msg_count_reg  <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            limit_reg      <= limit_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    pfs_pkg::REG_ENABLE:    enable_reg    <= cfg_wdata[0];
                    pfs_pkg::REG_MSG_COUNT: msg_count_reg <= cfg_wdata;
                    default:                enable_reg    <= enable_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        now_reg    <= now_next;
        cycle_reg  <= cycle_next;
        elap_reg   <= elap_next;
        e2_reg     <= e2_next;
        jump_reg   <= jump_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

endmodule

// ===== design/pfs_checker.sv =====
module pfs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [pfs_pkg::FUNC_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pfs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    // A frame held back by the sink keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled frame changed");

    // Nothing comes out of a block that was just reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("frame valid right after reset");

    // A slot write completes in the cycle it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == pfs_pkg::FUNC_WRITE |=> s_tready)
        else $error("slot write did not return to idle");

    // A restart sweeps the table before the next request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == pfs_pkg::FUNC_RESTART |=> !s_tready)
        else $error("restart did not sweep the table");

endmodule

bind periodic_frame_scheduler pfs_checker u_pfs_checker (.*);

// ===== dv/pfs_frame_checker.sv =====
module pfs_frame_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // s_tdata from bit 0: slot, frame_id, frame_length, frame_data, period_ms, now_us, zero pad
    input  logic [pfs_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: func
    input  logic [pfs_pkg::FUNC_W-1:0]        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: out_slot, out_id, out_length, out_data, zero pad
    input  logic [pfs_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [pfs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              drain_done,
    output int unsigned                       frames_pending,
    output int unsigned                       frames_checked,
    output int unsigned                       fail_count
);

    import pfs_pkg::*;

    localparam int S_PAD_W     = S_TDATA_W - S_FIELDS_W;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        logic              last;
    } due_frame_t;

    due_frame_t          due_frames[$];

    logic [ID_W-1:0]     tbl_id     [NUM_SLOTS];
    logic [LEN_W-1:0]    tbl_len    [NUM_SLOTS];
    logic [DATA_W-1:0]   tbl_data   [NUM_SLOTS];
    logic [PERIOD_W-1:0] tbl_period [NUM_SLOTS];
    logic [TIME_W-1:0]   tbl_sent   [NUM_SLOTS];

    logic                sched_on;
    logic [CFG_DATA_W-1:0] slots_used;
    bit                  leftovers_flagged;

    initial begin
        frames_pending    = 0;
        frames_checked    = 0;
        fail_count        = 0;
        leftovers_flagged = 1'b0;
        sched_on          = 1'b0;
        slots_used        = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_id[i]     = '0;
            tbl_len[i]    = '0;
            tbl_data[i]   = '0;
            tbl_period[i] = '0;
            tbl_sent[i]   = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTED) begin
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    task automatic predict_tick(input logic [TIME_W-1:0] now);
        int         scan;
        bit         have;
        due_frame_t held;
        logic [TIME_W-1:0] cycle;
        logic [TIME_W-1:0] elapsed;
        logic [DATA_W-1:0] mask;
        scan = int'(slots_used);
        if (scan > NUM_SLOTS) scan = NUM_SLOTS;
        if (scan > MAX_EMIT) scan = MAX_EMIT;
        have = 1'b0;
        held = '0;
        for (int i = 0; i < scan; i++) begin
            cycle   = 64'(tbl_period[i]) * 64'(US_PER_MS);
            elapsed = now - tbl_sent[i];
            if (cycle != 0 && elapsed >= cycle) begin
                // A frame is only final once no later slot turns out to be due.
                if (have) due_frames.push_back(held);
                if (tbl_len[i] >= MAX_LEN) mask = '1;
                else mask = (64'd1 << (8 * tbl_len[i])) - 64'd1;
                held.slot = SLOT_W'(i);
                held.id   = tbl_id[i];
                held.len  = tbl_len[i];
                held.data = tbl_data[i] & mask;
                held.last = 1'b0;
                have = 1'b1;
                tbl_sent[i] = tbl_sent[i] + cycle;
                if (now - tbl_sent[i] > cycle) tbl_sent[i] = now;
            end
        end
        if (have) begin
            held.last = 1'b1;
            due_frames.push_back(held);
        end
    endtask

    task automatic predict_request(input logic [FUNC_W-1:0] func,
                                   input logic [S_TDATA_W-1:0] req);
        logic [S_PAD_W-1:0]  pad;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        logic [DATA_W-1:0]   data;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   now;
        {pad, now, period, data, len, id, slot} = req;
        case (func)
            FUNC_WRITE: begin
                if (slot < NUM_SLOTS) begin
                    if (len > MAX_LEN) len = LEN_W'(MAX_LEN);
                    tbl_id[slot]     = id;
                    tbl_len[slot]    = len;
                    tbl_data[slot]   = data;
                    tbl_period[slot] = period;
                end
            end
            FUNC_RESTART: begin
                for (int i = 0; i < NUM_SLOTS; i++) tbl_sent[i] = now;
            end
            FUNC_TICK: begin
                if (sched_on) predict_tick(now);
            end
            default: ;
        endcase
    endtask

    task automatic check_frame();
        due_frame_t         want;
        logic [M_PAD_W-1:0] pad;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    id;
        logic [LEN_W-1:0]   len;
        logic [DATA_W-1:0]  data;
        {pad, data, len, id, slot} = m_tdata;
        frames_checked++;
        if (due_frames.size() == 0) begin
            report_mismatch("frame with nothing due, slot", 64'(slot), 64'd0);
        end else begin
            want = due_frames.pop_front();
            if (slot != want.slot) report_mismatch("out_slot", 64'(slot), 64'(want.slot));
            if (id != want.id) report_mismatch("out_id", 64'(id), 64'(want.id));
            if (len != want.len) report_mismatch("out_length", 64'(len), 64'(want.len));
            if (data != want.data) report_mismatch("out_data", data, want.data);
            if (m_tlast != want.last) report_mismatch("m_tlast", 64'(m_tlast), 64'(want.last));
            if (pad != '0) report_mismatch("m_tdata padding", 64'(pad), 64'd0);
        end
    endtask

    task automatic flag_leftovers();
        due_frame_t want;
        while (due_frames.size() != 0) begin
            want = due_frames.pop_front();
            report_mismatch("frame never sent, slot", 64'd0, 64'(want.slot));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            sched_on   = 1'b0;
            slots_used = '0;
            for (int i = 0; i < NUM_SLOTS; i++) tbl_sent[i] = '0;
            due_frames.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_ENABLE) sched_on = cfg_wdata[0];
                else if (cfg_addr == REG_MSG_COUNT) slots_used = cfg_wdata;
            end
            // Frames leaving now belong to requests taken at earlier edges.
            if (m_tvalid && m_tready) check_frame();
            if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
            if (drain_done && !leftovers_flagged) begin
                leftovers_flagged = 1'b1;
                flag_leftovers();
            end
        end
        frames_pending <= due_frames.size();
    end

endmodule

// ===== dv/periodic_frame_scheduler_tb.sv =====
module periodic_frame_scheduler_tb;

    import pfs_pkg::*;

    localparam int SETTLE_CYCLES = 160;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int S_PAD_W       = S_TDATA_W - S_FIELDS_W;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [FUNC_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   drain_done    = 1'b0;
    logic                   long_hold_req = 1'b0;

    int unsigned frames_pending;
    int unsigned frames_checked;
    int unsigned fail_count;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left   = 0;
    int unsigned n_writes     = 0;
    int unsigned n_ticks      = 0;
    int unsigned n_restarts   = 0;
    int unsigned n_ignored    = 0;
    logic [TIME_W-1:0] sim_now = '0;

    periodic_frame_scheduler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    pfs_frame_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .drain_done     (drain_done),
        .frames_pending (frames_pending),
        .frames_checked (frames_checked),
        .fail_count     (fail_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output side: random ready patterns, with one long hold-off on request.
    initial begin : frame_sink
        int unsigned pattern;
        int unsigned mode;
        bit          held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                pattern = $urandom;
                mode    = $urandom_range(0, 3);
                for (int k = 0; k < 32; k++) begin
                    if (mode == 0) m_tready <= 1'b1;
                    else if (mode == 1) m_tready <= pattern[k];
                    else if (mode == 2) m_tready <= pattern[k] | pattern[(k + 5) % 32];
                    else m_tready <= pattern[k] & pattern[(k + 3) % 32];
                    @(posedge aclk);
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return PERIOD_W'($urandom_range(1, 20));
        else if (r < 70) return '0;
        else if (r < 85) return PERIOD_W'($urandom_range(21, 500));
        else if (r < 95) return PERIOD_W'($urandom);
        else return '1;
    endfunction

    task automatic pace();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                             input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                             input logic [DATA_W-1:0] data, input logic [PERIOD_W-1:0] period,
                             input logic [TIME_W-1:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{S_PAD_W{1'b0}}, now, period, data, len, id, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (func == FUNC_WRITE) n_writes++;
        else if (func == FUNC_TICK) n_ticks++;
        else if (func == FUNC_RESTART) n_restarts++;
        else n_ignored++;
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] now);
        pace();
        send_item(FUNC_TICK, SLOT_W'($urandom), ID_W'($urandom), LEN_W'($urandom), rand64(),
                  PERIOD_W'($urandom), now);
    endtask

    task automatic send_restart(input logic [TIME_W-1:0] now);
        pace();
        send_item(FUNC_RESTART, SLOT_W'($urandom), ID_W'($urandom), LEN_W'($urandom),
                  rand64(), PERIOD_W'($urandom), now);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
    endtask

    // A tick over idle slots ends without a frame, so give the walk time to finish.
    task automatic wait_drain();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic enable_val, input logic [CFG_DATA_W-1:0] count_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_ENABLE;
        cfg_wdata <= {{(CFG_DATA_W - 1){1'b0}}, enable_val};
        @(posedge aclk);
        cfg_addr  <= REG_MSG_COUNT;
        cfg_wdata <= count_val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input int n_items, input bit with_hold, input bit with_pause);
        int          counted;
        int unsigned pick;
        int unsigned r;
        bit          paused;
        counted = 0;
        paused  = 1'b0;
        if (with_hold) long_hold_req <= 1'b1;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                r = $urandom_range(0, 99);
                if (r < 75) sim_now = sim_now + $urandom_range(0, 6000);
                else if (r < 95 && r >= 85) sim_now = sim_now + $urandom_range(100000, 70000000);
                else if (r >= 95) sim_now = rand64();
                send_tick(sim_now);
                counted++;
            end else if (pick < 84) begin
                pace();
                send_item(FUNC_WRITE, SLOT_W'($urandom), ID_W'($urandom),
                          LEN_W'($urandom_range(0, 15)), rand64(), pick_period(), rand64());
                counted++;
            end else if (pick < 93) begin
                r = $urandom_range(0, 9);
                if (r < 3) sim_now = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 50000);
                else if (r < 5) sim_now = rand64();
                send_restart(sim_now);
                counted++;
            end else begin
                pace();
                send_item(FUNC_UNUSED, SLOT_W'($urandom), ID_W'($urandom), LEN_W'($urandom),
                          rand64(), PERIOD_W'($urandom), rand64());
            end
            if (with_pause && !paused && counted >= n_items / 2) begin
                paused = 1'b1;
                hold_until_drained();
            end
        end
        wait_drain();
    endtask

    initial begin : stimulus
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        logic [DATA_W-1:0]   data;
        logic [PERIOD_W-1:0] period;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        set_config(1'b0, '0);

        // Disabled tick, then fill every slot before any tick may walk it.
        send_tick(rand64());
        for (int i = 0; i < NUM_SLOTS; i++) begin
            id     = ID_W'($urandom);
            len    = LEN_W'($urandom_range(0, 15));
            data   = rand64();
            period = PERIOD_W'($urandom_range(1, 5));
            if (i == 0) begin
                id = '0;
                len = '0;
                data = '1;
                period = PERIOD_W'(1);
            end else if (i == 1) begin
                id = '1;
                len = LEN_W'(MAX_LEN);
                data = '1;
                period = PERIOD_W'(1);
            end else if (i == 2) begin
                len = LEN_W'(9);
                period = PERIOD_W'(2);
            end else if (i == 3) begin
                len = '1;
                period = '1;
            end else if (i == 4) begin
                period = '0;
            end
            pace();
            send_item(FUNC_WRITE, SLOT_W'(i), id, len, data, period, rand64());
        end
        pace();
        send_item(FUNC_UNUSED, SLOT_W'($urandom), ID_W'($urandom), LEN_W'($urandom), rand64(),
                  PERIOD_W'($urandom), rand64());
        send_restart('0);
        wait_drain();

        set_config(1'b1, 5'd16);
        send_tick('0);
        send_tick(64'd1000);
        // Far ahead of every last-sent time: all cyclic slots fire and catch up to now.
        send_tick('1);
        send_restart(64'hFFFF_FFFF_FFFF_FFFF - 64'd1499);
        send_tick(64'hFFFF_FFFF_FFFF_FFFF - 64'd499);
        send_tick(64'd500);
        sim_now = 64'd500;
        wait_drain();

        set_config(1'b1, 5'd16);
        run_phase(55, 1, 1);
        set_config(1'b1, CFG_DATA_W'($urandom_range(1, 15)));
        run_phase(40, 0, 0);
        set_config(1'b1, '1);
        run_phase(40, 0, 0);
        set_config(1'b0, 5'd16);
        run_phase(15, 0, 0);
        set_config(1'b1, CFG_DATA_W'($urandom_range(0, 16)));
        run_phase(35, 0, 0);

        drain_done <= 1'b1;
        repeat (2) @(posedge aclk);
        $display("Sent %0d slot writes, %0d ticks, %0d restarts, %0d unused-func requests;",
                 n_writes, n_ticks, n_restarts, n_ignored);
        $display("%0d frames checked with the scheduler off and on, over 16, 31 and random counts.",
                 frames_checked);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pfs_pkg.sv
design/pfs_table.sv
design/pfs_alu.sv
design/periodic_frame_scheduler.sv
design/pfs_checker.sv
dv/pfs_frame_checker.sv
dv/periodic_frame_scheduler_tb.sv
